// File: rtl/core/wildcard_byte_signature_scan_assert.svh
// Assertion macros for the wildcard byte signature scan.
`ifndef WILDCARD_BYTE_SIGNATURE_SCAN_ASSERT_SVH
`define WILDCARD_BYTE_SIGNATURE_SCAN_ASSERT_SVH
`ifndef ASSERT_OFF
`define WBSS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("wbss: assertion failed");
`define WBSS_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("wbss: illegal condition");
`else
`define WBSS_ASSERT(lbl, clk, rst, prop)
`define WBSS_NEVER(lbl, clk, rst, expr)
`endif
`endif

// File: rtl/core/wbss_pkg.sv
// Shared types, constants and helper functions of the signature scan.
`timescale 1ns / 1ps
`default_nettype none

package wbss_pkg;

   localparam int MAX_PATTERN  = 128;
   localparam int IDX_W        = $clog2(MAX_PATTERN);
   localparam int LEN_W        = $clog2(MAX_PATTERN + 1);
   localparam int ADDR_SUM_W   = IDX_W + 2;
   localparam int CFG_W        = 8;
   localparam int CMP_W        = ((LEN_W > CFG_W) ? LEN_W : CFG_W) + 1;
   localparam int EIDX_W       = 7;
   localparam int EXT_W        = IDX_W + EIDX_W + 1;
   localparam int KIND_W       = 2;
   localparam int BYTE_W       = 8;
   localparam int WORD_W       = 32;
   localparam int COUNT_W      = 16;
   localparam int CAP_BYTES    = 4;
   localparam int CAP_W        = $clog2(CAP_BYTES);
   localparam int PAT_W        = KIND_W + BYTE_W;

   localparam logic          ACT_LOAD     = 1'b0;
   localparam logic          ACT_BYTE     = 1'b1;
   localparam logic [KIND_W-1:0] KIND_LITERAL = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WILD    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MARKER  = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NOT_FOUND  = 2'd1,
      STATUS_NOT_UNIQUE = 2'd2,
      STATUS_NO_MARKER  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CMP,
      S_CMP_DRAIN,
      S_EVAL,
      S_CAP,
      S_CAP_DRAIN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic cfg_write;
      logic load_elem;
      logic take_byte;
      logic cmp_issue;
      logic eval;
      logic cap_issue;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic window_full;
      logic cmp_last;
      logic hit;
      logic first_hit;
      logic marker_found;
      logic cap_last;
      logic last;
   } dp_status_type;

   // Step a circular address by one.
   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] a);
      logic [IDX_W-1:0] r;
      if (a == IDX_W'(MAX_PATTERN - 1)) begin
         r = '0;
      end else begin
         r = a + 1'b1;
      end
      return r;
   endfunction

   // Fold a sum known to stay below twice the depth back into range.
   function automatic logic [IDX_W-1:0] wrap_mod(input logic [ADDR_SUM_W-1:0] s);
      logic [IDX_W-1:0] r;
      if (s >= ADDR_SUM_W'(MAX_PATTERN)) begin
         r = IDX_W'(s - ADDR_SUM_W'(MAX_PATTERN));
      end else begin
         r = IDX_W'(s);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/wbss_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module wbss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: rtl/core/wbss_ctrl.sv
// Sequencer of the signature scan: steps each word through compare and capture.
`timescale 1ns / 1ps
`default_nettype none
`include "wildcard_byte_signature_scan_assert.svh"

module wbss_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_action,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire wbss_pkg::dp_status_type status,
   output wbss_pkg::dp_cmd_type         cmd
);
   import wbss_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.cfg_write = csr_valid && (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_action == ACT_LOAD) begin
                  cmd.load_elem = 1'b1;
               end else begin
                  cmd.take_byte = 1'b1;
                  state_in = status.window_full ? S_CMP : S_FINISH;
               end
            end
         end
         S_CMP: begin
            cmd.cmp_issue = 1'b1;
            if (status.cmp_last) begin
               state_in = S_CMP_DRAIN;
            end
         end
         S_CMP_DRAIN: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (status.hit && status.first_hit && status.marker_found) begin
               state_in = S_CAP;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_CAP: begin
            cmd.cap_issue = 1'b1;
            if (status.cap_last) begin
               state_in = S_CAP_DRAIN;
            end
         end
         S_CAP_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // A final word waits here until the output register is free.
            if (!status.last) begin
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `WBSS_ASSERT(a_eval_after_drain, clock, reset, state_ff == S_EVAL |-> $past(state_ff) == S_CMP_DRAIN)
   `WBSS_ASSERT(a_rsp_rise_on_emit, clock, reset, $rose(rsp_valid_ff) |-> $past(cmd.emit))

endmodule

`default_nettype wire

// File: rtl/core/wbss_datapath.sv
// Pattern and window stores, serial window compare, capture and result registers.
`timescale 1ns / 1ps
`default_nettype none
`include "wildcard_byte_signature_scan_assert.svh"

module wbss_datapath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire wbss_pkg::dp_cmd_type         cmd,
   output wbss_pkg::dp_status_type           status,
   input  wire logic [wbss_pkg::EIDX_W-1:0]  req_element_index,
   input  wire logic [wbss_pkg::KIND_W-1:0]  req_element_kind,
   input  wire logic [wbss_pkg::BYTE_W-1:0]  req_byte_value,
   input  wire logic                         req_region_last,
   input  wire logic [wbss_pkg::CFG_W-1:0]   csr_data,
   output logic      [1:0]                   rsp_status,
   output logic      [wbss_pkg::WORD_W-1:0]  rsp_captured_word,
   output logic      [wbss_pkg::COUNT_W-1:0] rsp_match_total
);
   import wbss_pkg::*;

   // Control and scan state.
   logic [CFG_W-1:0]   plen_ff, plen_in;
   logic [IDX_W-1:0]   wptr_ff, wptr_in;
   logic [LEN_W-1:0]   seen_ff, seen_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               last_ff, last_in;
   logic [IDX_W-1:0]   j_ff, j_in;
   logic               chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]   chk_j_ff, chk_j_in;
   logic               mismatch_ff, mismatch_in;
   logic               mfound_ff, mfound_in;
   logic [IDX_W-1:0]   midx_ff, midx_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               marker_ff, marker_in;
   logic [CAP_W-1:0]   pend_ff, pend_in;
   logic [CAP_W-1:0]   o_ff, o_in;
   logic               cap_chk_ff, cap_chk_in;
   logic [CAP_W-1:0]   cap_o_ff, cap_o_in;

   // Payload registers.
   logic [IDX_W-1:0]   rd_addr_ff, rd_addr_in;
   logic [IDX_W-1:0]   base_ff, base_in;
   logic [WORD_W-1:0]  cap_word_ff, cap_word_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0]  rsp_word_ff, rsp_word_in;
   logic [COUNT_W-1:0] rsp_total_ff, rsp_total_in;

   logic [EXT_W-1:0]      idx_ext;
   logic                  idx_in_range;
   logic [PAT_W-1:0]      pat_rdata;
   logic [BYTE_W-1:0]     win_rdata;
   logic [LEN_W-1:0]      len_eff;
   logic [LEN_W-1:0]      seen_next;
   logic [IDX_W-1:0]      base_now;
   logic [IDX_W-1:0]      cap_start;
   logic [LEN_W:0]        pend_sum;
   logic [CAP_W-1:0]      pend_calc;
   logic [CAP_W-1:0]      pend_slot;
   logic                  cap_in_range;
   logic [KIND_W-1:0]     chk_kind;
   logic [BYTE_W-1:0]     chk_byte;

   assign idx_ext      = EXT_W'(req_element_index);
   assign idx_in_range = idx_ext < EXT_W'(MAX_PATTERN);

   wbss_ram #(
      .WIDTH (PAT_W),
      .DEPTH (MAX_PATTERN)
   ) u_pattern_ram (
      .clock   (clock),
      .wr_en   (cmd.load_elem && idx_in_range),
      .wr_addr (idx_ext[IDX_W-1:0]),
      .wr_data ({req_element_kind, req_byte_value}),
      .rd_addr (j_ff),
      .rd_data (pat_rdata)
   );

   wbss_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_PATTERN)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (cmd.take_byte),
      .wr_addr (wptr_ff),
      .wr_data (req_byte_value),
      .rd_addr (rd_addr_ff),
      .rd_data (win_rdata)
   );

   always_comb begin
      if (plen_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (CMP_W'(plen_ff) > CMP_W'(MAX_PATTERN)) begin
         len_eff = LEN_W'(MAX_PATTERN);
      end else begin
         len_eff = LEN_W'(plen_ff);
      end
   end

   assign seen_next = (seen_ff == LEN_W'(MAX_PATTERN)) ? seen_ff : seen_ff + 1'b1;

   // The oldest byte of the window sits len-1 places behind the newest one.
   assign base_now = wrap_mod(ADDR_SUM_W'(wptr_ff) + ADDR_SUM_W'(MAX_PATTERN)
                              + ADDR_SUM_W'(1) - ADDR_SUM_W'(len_eff));

   assign cap_start = wrap_mod(ADDR_SUM_W'(base_ff) + ADDR_SUM_W'(midx_ff));
   assign pend_sum  = (LEN_W + 1)'(midx_ff) + (LEN_W + 1)'(CAP_BYTES);
   assign pend_calc = (pend_sum > (LEN_W + 1)'(len_ff))
                      ? CAP_W'(pend_sum - (LEN_W + 1)'(len_ff)) : '0;
   assign pend_slot = CAP_W'((CAP_W + 1)'(CAP_BYTES) - (CAP_W + 1)'(pend_ff));
   assign cap_in_range = ((LEN_W + 1)'(midx_ff) + (LEN_W + 1)'(cap_o_ff))
                         < (LEN_W + 1)'(len_ff);
   assign chk_kind = pat_rdata[PAT_W-1:BYTE_W];
   assign chk_byte = pat_rdata[BYTE_W-1:0];

   always_comb begin
      plen_in       = plen_ff;
      wptr_in       = wptr_ff;
      seen_in       = seen_ff;
      len_in        = len_ff;
      last_in       = last_ff;
      j_in          = j_ff;
      mismatch_in   = mismatch_ff;
      mfound_in     = mfound_ff;
      midx_in       = midx_ff;
      count_in      = count_ff;
      marker_in     = marker_ff;
      pend_in       = pend_ff;
      o_in          = o_ff;
      rd_addr_in    = rd_addr_ff;
      base_in       = base_ff;
      cap_word_in   = cap_word_ff;
      rsp_status_in = rsp_status_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_total_in  = rsp_total_ff;
      chk_valid_in  = cmd.cmp_issue;
      chk_j_in      = j_ff;
      cap_chk_in    = cmd.cap_issue;
      cap_o_in      = o_ff;

      if (cmd.cfg_write) begin
         plen_in = csr_data;
      end

      if (cmd.take_byte) begin
         // Bytes of the captured word that lay past the window come in here.
         if (pend_ff != '0) begin
            cap_word_in[{pend_slot, 3'b000} +: BYTE_W] = req_byte_value;
            pend_in = pend_ff - 1'b1;
         end
         wptr_in     = wrap_inc(wptr_ff);
         seen_in     = seen_next;
         len_in      = len_eff;
         last_in     = req_region_last;
         base_in     = base_now;
         rd_addr_in  = base_now;
         j_in        = '0;
         mismatch_in = 1'b0;
         mfound_in   = 1'b0;
         midx_in     = '0;
      end

      if (cmd.cmp_issue) begin
         j_in       = j_ff + 1'b1;
         rd_addr_in = wrap_inc(rd_addr_ff);
      end

      if (chk_valid_ff) begin
         if (chk_kind == KIND_LITERAL && chk_byte != win_rdata) begin
            mismatch_in = 1'b1;
         end
         if (chk_kind == KIND_MARKER && !mfound_ff) begin
            mfound_in = 1'b1;
            midx_in   = chk_j_ff;
         end
      end

      if (cmd.eval && !mismatch_ff) begin
         if (count_ff == '0) begin
            marker_in   = mfound_ff;
            cap_word_in = '0;
            pend_in     = mfound_ff ? pend_calc : '0;
            rd_addr_in  = cap_start;
            o_in        = '0;
         end
         if (count_ff != '1) begin
            count_in = count_ff + 1'b1;
         end
      end

      if (cmd.cap_issue) begin
         o_in       = o_ff + 1'b1;
         rd_addr_in = wrap_inc(rd_addr_ff);
      end

      if (cap_chk_ff && cap_in_range) begin
         cap_word_in[{cap_o_ff, 3'b000} +: BYTE_W] = win_rdata;
      end

      if (cmd.emit) begin
         if (count_ff == '0) begin
            rsp_status_in = STATUS_NOT_FOUND;
            rsp_word_in   = '0;
         end else if (count_ff != COUNT_W'(1)) begin
            rsp_status_in = STATUS_NOT_UNIQUE;
            rsp_word_in   = '0;
         end else if (!marker_ff) begin
            rsp_status_in = STATUS_NO_MARKER;
            rsp_word_in   = '0;
         end else begin
            rsp_status_in = STATUS_OK;
            rsp_word_in   = cap_word_ff;
         end
         rsp_total_in = count_ff;
         seen_in      = '0;
         count_in     = '0;
         marker_in    = 1'b0;
         pend_in      = '0;
         cap_word_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff      <= CFG_W'(1);
         wptr_ff      <= '0;
         seen_ff      <= '0;
         len_ff       <= LEN_W'(1);
         last_ff      <= 1'b0;
         j_ff         <= '0;
         chk_valid_ff <= 1'b0;
         chk_j_ff     <= '0;
         mismatch_ff  <= 1'b0;
         mfound_ff    <= 1'b0;
         midx_ff      <= '0;
         count_ff     <= '0;
         marker_ff    <= 1'b0;
         pend_ff      <= '0;
         o_ff         <= '0;
         cap_chk_ff   <= 1'b0;
         cap_o_ff     <= '0;
         cap_word_ff  <= '0;
      end else begin
         plen_ff      <= plen_in;
         wptr_ff      <= wptr_in;
         seen_ff      <= seen_in;
         len_ff       <= len_in;
         last_ff      <= last_in;
         j_ff         <= j_in;
         chk_valid_ff <= chk_valid_in;
         chk_j_ff     <= chk_j_in;
         mismatch_ff  <= mismatch_in;
         mfound_ff    <= mfound_in;
         midx_ff      <= midx_in;
         count_ff     <= count_in;
         marker_ff    <= marker_in;
         pend_ff      <= pend_in;
         o_ff         <= o_in;
         cap_chk_ff   <= cap_chk_in;
         cap_o_ff     <= cap_o_in;
         cap_word_ff  <= cap_word_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff    <= rd_addr_in;
      base_ff       <= base_in;
      rsp_status_ff <= rsp_status_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_total_ff  <= rsp_total_in;
   end

   always_comb begin
      status.window_full  = seen_next >= len_eff;
      status.cmp_last     = LEN_W'(j_ff) == (len_ff - 1'b1);
      status.hit          = !mismatch_ff;
      status.first_hit    = count_ff == '0;
      status.marker_found = mfound_ff;
      status.cap_last     = o_ff == CAP_W'(CAP_BYTES - 1);
      status.last         = last_ff;
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_captured_word = rsp_word_ff;
   assign rsp_match_total   = rsp_total_ff;

   `WBSS_ASSERT(a_cmp_index_in_len, clock, reset, cmd.cmp_issue |-> LEN_W'(j_ff) < len_ff)
   `WBSS_NEVER(a_cmp_cap_overlap, clock, reset, chk_valid_ff && cap_chk_ff)

endmodule

`default_nettype wire

// File: rtl/core/wildcard_byte_signature_scan.sv
// Top level of the wildcard byte signature scan: controller plus datapath.
//
//   Channel  Dir  Handshake          Word
//   req_     in   valid / stall      pattern element load or one region byte
//   rsp_     out  valid / stall      status, captured word, match total
//   csr_     in   valid / ready      pattern_length
//
// A pattern load is taken while idle. Once a full window of len bytes has been
// seen, a region byte runs compare, drain and evaluate, else goes to finish;
// the first matching window with a marker then reads the captured word.
// The window compare walks one pattern element per cycle through the pattern
// and window RAM read ports. Reset clears all scan state; pattern_length
// resets to 1 and the pattern store is undefined until loaded. A final byte
// waits in the controller while an earlier result is still stalled.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_byte_signature_scan (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_action,
   input  wire logic [wbss_pkg::EIDX_W-1:0]  req_element_index,
   input  wire logic [wbss_pkg::KIND_W-1:0]  req_element_kind,
   input  wire logic [wbss_pkg::BYTE_W-1:0]  req_byte_value,
   input  wire logic                         req_region_last,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [1:0]                   rsp_status,
   output logic      [wbss_pkg::WORD_W-1:0]  rsp_captured_word,
   output logic      [wbss_pkg::COUNT_W-1:0] rsp_match_total,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [wbss_pkg::CFG_W-1:0]   csr_data
);
   import wbss_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   wbss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .status     (status),
      .cmd        (cmd)
   );

   wbss_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_element_index (req_element_index),
      .req_element_kind  (req_element_kind),
      .req_byte_value    (req_byte_value),
      .req_region_last   (req_region_last),
      .csr_data          (csr_data),
      .rsp_status        (rsp_status),
      .rsp_captured_word (rsp_captured_word),
      .rsp_match_total   (rsp_match_total)
   );

endmodule

`default_nettype wire
